// ===== rtl/csbd_pkg.sv =====
// Shared types and constants for the charset byte stream decoder.
package csbd_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CP_W        = 21;
  localparam int LEN_W       = 3;
  localparam int TOT_W       = 16;

  typedef enum logic [1:0] {
    CS_UCS2   = 2'd0,
    CS_UTF8   = 2'd1,
    CS_LATIN1 = 2'd2,
    CS_ASCII  = 2'd3
  } charset_t;

  localparam charset_t CHARSET_RESET = CS_UTF8;

  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] seq_bytes;
    logic             end_of_string;
    logic             bad_format;
    logic [TOT_W-1:0] char_total;
    logic [TOT_W-1:0] byte_total;
  } result_t;

  function automatic logic cont_ok(input logic [7:0] b);
    cont_ok = ((b & CONT_MASK) == CONT_TAG);
  endfunction

endpackage

// ===== rtl/csbd_decode.sv =====
// Per-byte decode: charset register, partial character state and counts.
module csbd_decode import csbd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_data,
  input  logic [7:0] data_byte,
  input  logic       step,
  output logic       emit,
  output result_t    res
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  charset_t               charset_r, charset_nxt;
  logic [23:0]            held_r, held_nxt;
  logic [LEN_W-1:0]       expected_r, expected_nxt;
  logic [LEN_W-1:0]       collected_r, collected_nxt;
  logic [COUNT_WIDTH-1:0] chars_r, chars_nxt;
  logic [COUNT_WIDTH-1:0] bytes_r, bytes_nxt;

  logic [CP_W-1:0]        cp_raw;
  logic [LEN_W-1:0]       n;
  logic                   bad;
  logic                   report;
  logic [COUNT_WIDTH:0]   byte_sum;
  logic [COUNT_WIDTH:0]   char_sum;
  logic [COUNT_WIDTH-1:0] byte_sat;
  logic [COUNT_WIDTH-1:0] char_sat;
  logic [COUNT_WIDTH+TOT_W-1:0] chars_ext;
  logic [COUNT_WIDTH+TOT_W-1:0] bytes_ext;

  // Classify the byte against the partial character in progress.
  always_comb begin
    emit          = 1'b0;
    cp_raw        = '0;
    n             = 3'd1;
    bad           = 1'b0;
    held_nxt      = held_r;
    expected_nxt  = expected_r;
    collected_nxt = collected_r;
    if (expected_r == '0) begin
      case (charset_r)
        CS_UCS2: begin
          held_nxt = {16'h0, data_byte}; expected_nxt = 3'd2; collected_nxt = 3'd1;
        end
        CS_UTF8: begin
          case (data_byte[7:4]) inside
            [4'h0:4'h7]: begin
              emit = 1'b1; cp_raw = CP_W'(data_byte);
            end
            4'hC, 4'hD: begin
              held_nxt = {16'h0, data_byte}; expected_nxt = 3'd2; collected_nxt = 3'd1;
            end
            4'hE: begin
              held_nxt = {16'h0, data_byte}; expected_nxt = 3'd3; collected_nxt = 3'd1;
            end
            4'hF: begin
              held_nxt = {16'h0, data_byte}; expected_nxt = 3'd4; collected_nxt = 3'd1;
            end
            default: begin
              emit = 1'b1; bad = 1'b1;
            end
          endcase
        end
        default: begin
          emit = 1'b1; cp_raw = CP_W'(data_byte);
        end
      endcase
    end else if (collected_r + 3'd1 < expected_r) begin
      held_nxt      = {held_r[15:0], data_byte};
      collected_nxt = collected_r + 3'd1;
    end else begin
      emit          = 1'b1;
      n             = expected_r;
      held_nxt      = '0;
      expected_nxt  = '0;
      collected_nxt = '0;
      if (charset_r == CS_UCS2) begin
        cp_raw = CP_W'({held_r[7:0], data_byte});
      end else begin
        case (expected_r)
          3'd2: begin
            bad    = !cont_ok(data_byte);
            cp_raw = CP_W'({held_r[4:0], data_byte[5:0]});
          end
          3'd3: begin
            bad    = !cont_ok(held_r[7:0]) || !cont_ok(data_byte);
            cp_raw = CP_W'({held_r[11:8], held_r[5:0], data_byte[5:0]});
          end
          default: begin
            bad    = !cont_ok(held_r[15:8]) || !cont_ok(held_r[7:0]) ||
                     !cont_ok(data_byte);
            cp_raw = {held_r[18:16], held_r[13:8], held_r[5:0], data_byte[5:0]};
          end
        endcase
      end
    end
  end

  // Saturating counts; report and clear on terminator or error.
  assign byte_sum  = {1'b0, bytes_r} + (COUNT_WIDTH+1)'(n);
  assign char_sum  = {1'b0, chars_r} + (COUNT_WIDTH+1)'(1);
  assign byte_sat  = byte_sum[COUNT_WIDTH] ? CNT_MAX : byte_sum[COUNT_WIDTH-1:0];
  assign char_sat  = char_sum[COUNT_WIDTH] ? CNT_MAX : char_sum[COUNT_WIDTH-1:0];
  assign report    = bad || (cp_raw == '0);
  assign chars_ext = {{TOT_W{1'b0}}, chars_r};
  assign bytes_ext = {{TOT_W{1'b0}}, byte_sat};

  always_comb begin
    res.code_point    = bad ? '0 : cp_raw;
    res.seq_bytes     = n;
    res.end_of_string = report && !bad;
    res.bad_format    = bad;
    res.char_total    = report ? chars_ext[TOT_W-1:0] : '0;
    res.byte_total    = report ? bytes_ext[TOT_W-1:0] : '0;
    chars_nxt         = chars_r;
    bytes_nxt         = bytes_r;
    if (emit) begin
      bytes_nxt = report ? '0 : byte_sat;
      chars_nxt = report ? '0 : char_sat;
    end
  end

  assign charset_nxt = charset_t'(cfg_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      charset_r   <= CHARSET_RESET;
      held_r      <= '0;
      expected_r  <= '0;
      collected_r <= '0;
      chars_r     <= '0;
      bytes_r     <= '0;
    end else if (cfg_we) begin
      charset_r   <= charset_nxt;
      held_r      <= '0;
      expected_r  <= '0;
      collected_r <= '0;
    end else if (step) begin
      held_r      <= held_nxt;
      expected_r  <= expected_nxt;
      collected_r <= collected_nxt;
      chars_r     <= chars_nxt;
      bytes_r     <= bytes_nxt;
    end
  end

endmodule

// ===== rtl/charset_byte_stream_decoder.sv =====
// Top level: input register, per-byte decode and result register.
//
// Usage:
//   Bytes of a null-terminated string enter on the in_ channel (valid/ready),
//   one transaction per byte. Each completed character leaves as one
//   transaction on the out_ channel with its code point, byte length,
//   terminator and error flags, and the character and byte totals, which
//   are nonzero only on the terminator or an error result.
//   cfg_we/cfg_data write the charset (0 UCS-2 BE, 1 UTF-8, 2 Latin-1,
//   3 ASCII); a write drops any partial character. Write only when idle.
// Path: a byte accepted on the in_ channel is captured in the input register,
//   decoded from it, and its result is loaded into the output register,
//   from which the output transaction is taken.
// Throughput: one byte per cycle, set by the single decode step between
//   the input and output registers, unless a result waits on a stall.
// Reset: charset returns to UTF-8, partial character and counts clear,
//   both pipeline registers empty.
// Stall: while out_ready is low, bytes that complete no character still
//   advance; a byte that gives a result holds in the input register until
//   the output register drains, and in_ready drops behind it.
module charset_byte_stream_decoder import csbd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_data_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CP_W-1:0]  out_code_point,
  output logic [LEN_W-1:0] out_seq_bytes,
  output logic             out_end_of_string,
  output logic             out_bad_format,
  output logic [TOT_W-1:0] out_char_total,
  output logic [TOT_W-1:0] out_byte_total,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_data
);

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_r;
  logic       emit;
  logic       advance;
  result_t    res;

  csbd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .data_byte (in_byte_r),
    .step      (advance),
    .emit      (emit),
    .res       (res)
  );

  // Advance the held byte unless its result has nowhere to go.
  assign advance  = in_valid_r && (!emit || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (advance) in_valid_nxt = 1'b0;
    if (in_valid && in_ready) in_valid_nxt = 1'b1;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (advance && emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: capture on acceptance, load result on advance.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_byte_r <= in_data_byte;
    if (advance && emit)      out_r     <= res;
  end

  assign out_valid         = out_valid_r;
  assign out_code_point    = out_r.code_point;
  assign out_seq_bytes     = out_r.seq_bytes;
  assign out_end_of_string = out_r.end_of_string;
  assign out_bad_format    = out_r.bad_format;
  assign out_char_total    = out_r.char_total;
  assign out_byte_total    = out_r.byte_total;

`ifndef SYNTHESIS
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_byte_r))
    else $error("held input byte lost or changed");

  a_eos_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_string |-> out_code_point == '0 && !out_bad_format)
    else $error("terminator result malformed");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_format |-> out_code_point == '0 && !out_end_of_string)
    else $error("error result carries a code point");

  a_totals_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_end_of_string && !out_bad_format |->
      out_char_total == '0 && out_byte_total == '0)
    else $error("ordinary character reports totals");
`endif

endmodule
